/* design/bft_pkg.sv */
// ----------------------------------------------------------------------------
// bft_pkg
// Shared types and codes of the bidirectional flow table.
// ----------------------------------------------------------------------------
package bft_pkg;

	// event codes of a result
	localparam logic [2:0] EV_IGNORED   = 3'd0;
	localparam logic [2:0] EV_NEW       = 3'd1;
	localparam logic [2:0] EV_UPDATED   = 3'd2;
	localparam logic [2:0] EV_CLOSED    = 3'd3;
	localparam logic [2:0] EV_FULL      = 3'd4;
	localparam logic [2:0] EV_TIMED_OUT = 3'd5;
	localparam logic [2:0] EV_NONE_IDLE = 3'd6;

	// protocols tracked
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;

	// item modes
	localparam logic MODE_PACKET = 1'b0;
	localparam logic MODE_TICK   = 1'b1;

	// configuration register indexes
	localparam logic REG_PACKET_LIMIT = 1'b0;
	localparam logic REG_IDLE_TIMEOUT = 1'b1;

	localparam logic [15:0] PACKET_LIMIT_RST = 16'd1000;
	localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd60;

	typedef struct packed {
		logic [31:0] a_lo;
		logic [31:0] a_hi;
		logic [15:0] p_first;
		logic [15:0] p_second;
		logic [7:0]  proto;
	} flow_key_t;

	// classified item in the queue between front and back
	typedef struct packed {
		logic        mode;
		logic        tracked;
		flow_key_t   key;
		logic [31:0] tstamp;
	} fq_item_t;

	typedef struct packed {
		logic [2:0]  code;
		logic [5:0]  slot;
		logic [15:0] pkts;
		flow_key_t   key;
		logic        last;
	} result_t;

	typedef struct packed {
		logic [15:0] limit;
		logic [15:0] timeout;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MATCH,
		ST_READ,
		ST_UPDATE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_SCAN_END
	} back_state_t;

endpackage

/* design/bft_front.sv */
// ----------------------------------------------------------------------------
// bft_front
// Accepts items, normalizes the flow key, and queues them for the back end.
// ----------------------------------------------------------------------------
module bft_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              mode,
	input  logic [31:0]       src_addr,
	input  logic [31:0]       dst_addr,
	input  logic [15:0]       src_port,
	input  logic [15:0]       dst_port,
	input  logic [7:0]        proto_number,
	input  logic [31:0]       time_seconds,
	output bft_pkg::fq_item_t head,
	output logic              head_valid,
	input  logic              pop
);
	import bft_pkg::*;

	fq_item_t    cls_c;
	logic        swap_c;
	logic        push;
	fq_item_t    fifo_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;

	// classify and normalize so both directions share one key
	always_comb begin
		swap_c = (src_addr > dst_addr) || ((src_addr == dst_addr) && (src_port > dst_port));
		cls_c.mode    = mode;
		cls_c.tracked = (proto_number == PROTO_TCP) || (proto_number == PROTO_UDP);
		cls_c.tstamp  = time_seconds;
		cls_c.key.proto = proto_number;
		if (swap_c) begin
			cls_c.key.a_lo     = dst_addr;
			cls_c.key.a_hi     = src_addr;
			cls_c.key.p_first  = dst_port;
			cls_c.key.p_second = src_port;
		end else begin
			cls_c.key.a_lo     = src_addr;
			cls_c.key.a_hi     = dst_addr;
			cls_c.key.p_first  = src_port;
			cls_c.key.p_second = dst_port;
		end
	end

	assign item_stall = (count_q == 2'd2);
	assign push       = item_valid && !item_stall;
	assign head_valid = (count_q != 2'd0);
	assign head       = fifo_q[rd_ptr_q];

	// two-entry queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= cls_c;
		end
	end

	// queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* design/bft_back.sv */
// ----------------------------------------------------------------------------
// bft_back
// Flow table: parallel key match, count/timestamp update, timeout scan.
// ----------------------------------------------------------------------------
module bft_back #(
	parameter int FLOW_SLOTS = 64
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bft_pkg::fq_item_t head,
	input  logic              head_valid,
	output logic              pop,
	input  bft_pkg::cfg_t     cfg,
	output bft_pkg::result_t  result,
	output logic              result_valid,
	input  logic              result_stall
);
	import bft_pkg::*;

	localparam int SW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
	localparam logic [SW-1:0] LAST_SLOT = SW'(FLOW_SLOTS - 1);

	back_state_t state_q, state_d;

	// table storage
	logic [FLOW_SLOTS-1:0] valid_q;
	flow_key_t             key_q    [FLOW_SLOTS];
	flow_key_t             kmem     [FLOW_SLOTS];
	logic [15:0]           cnt_mem  [FLOW_SLOTS];
	logic [31:0]           ls_mem   [FLOW_SLOTS];
	flow_key_t             kmem_rd_q;
	logic [15:0]           cnt_rd_q;
	logic [31:0]           ls_rd_q;

	// lookup results
	logic [FLOW_SLOTS-1:0] match_q;
	logic [FLOW_SLOTS-1:0] free_q;
	logic [SW-1:0]         hit_idx_c, free_idx_c;
	logic                  hit_c, free_c;
	logic [SW-1:0]         hit_idx_q, free_idx_q;
	logic                  hit_q, free_found_q;

	// scan state
	logic [SW-1:0] scan_idx_q;
	logic          pend_q;
	result_t       pend_res_q;

	// control
	logic          out_free;
	logic          emit;
	result_t       emit_res;
	logic [SW-1:0] rd_addr_c;
	logic [15:0]   cnt_inc_c;
	logic          timed_c;
	logic          upd_do;
	logic          chk_go;
	result_t       res_q;
	logic          res_valid_q;

	assign out_free     = !res_valid_q || !result_stall;
	assign result       = res_q;
	assign result_valid = res_valid_q;

	// priority encoders over the registered match and free vectors
	always_comb begin
		hit_c      = 1'b0;
		free_c     = 1'b0;
		hit_idx_c  = '0;
		free_idx_c = '0;
		for (int i = FLOW_SLOTS - 1; i >= 0; i--) begin
			if (match_q[i]) begin
				hit_c     = 1'b1;
				hit_idx_c = SW'(i);
			end
			if (free_q[i]) begin
				free_c     = 1'b1;
				free_idx_c = SW'(i);
			end
		end
	end

	assign rd_addr_c = (state_q == ST_READ) ? hit_idx_c : scan_idx_q;
	assign cnt_inc_c = (cnt_rd_q == 16'hFFFF) ? cnt_rd_q : cnt_rd_q + 16'd1;
	assign timed_c   = valid_q[scan_idx_q] && (head.tstamp >= ls_rd_q) &&
	                   ((head.tstamp - ls_rd_q) > {16'd0, cfg.timeout});

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid) begin
					if (head.mode == MODE_TICK) begin
						state_d = ST_SCAN_RD;
					end else if (head.tracked) begin
						state_d = ST_MATCH;
					end
				end
			end
			ST_MATCH:   state_d = ST_READ;
			ST_READ:    state_d = ST_UPDATE;
			ST_UPDATE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN_RD: state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (!(timed_c && pend_q && !out_free)) begin
					state_d = (scan_idx_q == LAST_SLOT) ? ST_SCAN_END : ST_SCAN_RD;
				end
			end
			ST_SCAN_END: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// outputs of the state machine
	always_comb begin
		emit     = 1'b0;
		pop      = 1'b0;
		upd_do   = 1'b0;
		chk_go   = 1'b0;
		emit_res = '0;
		emit_res.last = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				if (head_valid && (head.mode == MODE_PACKET) && !head.tracked && out_free) begin
					emit          = 1'b1;
					pop           = 1'b1;
					emit_res.code = EV_IGNORED;
				end
			end
			ST_UPDATE: begin
				emit         = out_free;
				pop          = out_free;
				upd_do       = out_free;
				emit_res.key = head.key;
				if (hit_q) begin
					emit_res.code = (cnt_inc_c >= cfg.limit) ? EV_CLOSED : EV_UPDATED;
					emit_res.slot = 6'(hit_idx_q);
					emit_res.pkts = cnt_inc_c;
				end else if (free_found_q) begin
					emit_res.code = EV_NEW;
					emit_res.slot = 6'(free_idx_q);
					emit_res.pkts = 16'd1;
				end else begin
					emit_res.code = EV_FULL;
				end
			end
			ST_SCAN_CHK: begin
				chk_go = !(timed_c && pend_q && !out_free);
				if (timed_c && pend_q && out_free) begin
					emit     = 1'b1;
					emit_res = pend_res_q;
					emit_res.last = 1'b0;
				end
			end
			ST_SCAN_END: begin
				emit = out_free;
				pop  = out_free;
				if (pend_q) begin
					emit_res = pend_res_q;
					emit_res.last = 1'b1;
				end else begin
					emit_res.code = EV_NONE_IDLE;
				end
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	// state and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			valid_q     <= '0;
			res_valid_q <= 1'b0;
			pend_q      <= 1'b0;
			scan_idx_q  <= '0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
			// table valid bits
			if (upd_do) begin
				if (hit_q) begin
					if (cnt_inc_c >= cfg.limit) begin
						valid_q[hit_idx_q] <= 1'b0;
					end
				end else if (free_found_q) begin
					valid_q[free_idx_q] <= 1'b1;
				end
			end
			if (chk_go && timed_c) begin
				valid_q[scan_idx_q] <= 1'b0;
			end
			// scan walk and held result
			if (state_q == ST_IDLE) begin
				scan_idx_q <= '0;
				pend_q     <= 1'b0;
			end else if (chk_go) begin
				if (timed_c) begin
					pend_q <= 1'b1;
				end
				if (scan_idx_q != LAST_SLOT) begin
					scan_idx_q <= scan_idx_q + 1'b1;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (emit) begin
			res_q <= emit_res;
		end
		if (state_q == ST_MATCH) begin
			for (int i = 0; i < FLOW_SLOTS; i++) begin
				match_q[i] <= valid_q[i] && (key_q[i] == head.key);
				free_q[i]  <= !valid_q[i];
			end
		end
		if (state_q == ST_READ) begin
			hit_q        <= hit_c;
			hit_idx_q    <= hit_idx_c;
			free_found_q <= free_c;
			free_idx_q   <= free_idx_c;
		end
		if (chk_go && timed_c) begin
			pend_res_q.code <= EV_TIMED_OUT;
			pend_res_q.slot <= 6'(scan_idx_q);
			pend_res_q.pkts <= cnt_rd_q;
			pend_res_q.key  <= kmem_rd_q;
			pend_res_q.last <= 1'b0;
		end
	end

	// table memories: one write, one registered read held while the result waits
	always_ff @(posedge clk) begin
		if ((state_q == ST_READ) || (state_q == ST_SCAN_RD)) begin
			cnt_rd_q  <= cnt_mem[rd_addr_c];
			ls_rd_q   <= ls_mem[rd_addr_c];
			kmem_rd_q <= kmem[rd_addr_c];
		end
		if (upd_do) begin
			if (hit_q) begin
				cnt_mem[hit_idx_q] <= cnt_inc_c;
				ls_mem[hit_idx_q]  <= head.tstamp;
			end else if (free_found_q) begin
				cnt_mem[free_idx_q] <= 16'd1;
				ls_mem[free_idx_q]  <= head.tstamp;
				kmem[free_idx_q]    <= head.key;
				key_q[free_idx_q]   <= head.key;
			end
		end
	end

endmodule

/* design/bidirectional_flow_table.sv */
// ----------------------------------------------------------------------------
// bidirectional_flow_table
// Five-tuple flow table with packet limit and idle timeout.
// ----------------------------------------------------------------------------
// Input channel (item_valid/item_stall): one transfer per packet or tick.
// Packets are keyed so both directions of a conversation share a slot;
// only TCP and UDP are tracked. A tick walks every slot and closes idle flows.
// Output channel (result_valid/result_stall): one result per packet, one per
// closed flow on a tick (or one "none timed out"); last_of_run marks the end.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 packet limit,
// index 1 idle timeout; write only while the block is idle.
// In the back end a tracked packet passes through key match, slot encode and
// memory read, then update; an untracked packet is answered from idle; a tick
// reads the count and timestamp memories slot by slot, each slot being read
// and then checked. A two-entry queue sits between the front classifier and
// the back end, so input transfers continue during work.
// Reset empties the table and restores limit 1000 and timeout 60 seconds.
// A stalled result is held in the output register and the back end waits.
module bidirectional_flow_table #(
	parameter int FLOW_SLOTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        mode,
	input  logic [31:0] src_addr,
	input  logic [31:0] dst_addr,
	input  logic [15:0] src_port,
	input  logic [15:0] dst_port,
	input  logic [7:0]  proto_number,
	input  logic [31:0] time_seconds,
	output logic        result_valid,
	input  logic        result_stall,
	output logic [2:0]  event_code,
	output logic [5:0]  slot_index,
	output logic [15:0] flow_packets,
	output logic [31:0] key_addr_low,
	output logic [31:0] key_addr_high,
	output logic [15:0] key_port_first,
	output logic [15:0] key_port_second,
	output logic [7:0]  key_proto,
	output logic        last_of_run,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_index,
	input  logic [15:0] cfg_data
);
	import bft_pkg::*;

	fq_item_t head;
	logic     head_valid;
	logic     pop;
	cfg_t     cfg_q;
	result_t  res;

	// configuration registers
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.limit   <= PACKET_LIMIT_RST;
			cfg_q.timeout <= IDLE_TIMEOUT_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_PACKET_LIMIT: cfg_q.limit   <= cfg_data;
				REG_IDLE_TIMEOUT: cfg_q.timeout <= cfg_data;
				default:          cfg_q.limit   <= cfg_q.limit;
			endcase
		end
	end

	bft_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.mode         (mode),
		.src_addr     (src_addr),
		.dst_addr     (dst_addr),
		.src_port     (src_port),
		.dst_port     (dst_port),
		.proto_number (proto_number),
		.time_seconds (time_seconds),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop)
	);

	bft_back #(.FLOW_SLOTS(FLOW_SLOTS)) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (head_valid),
		.pop          (pop),
		.cfg          (cfg_q),
		.result       (res),
		.result_valid (result_valid),
		.result_stall (result_stall)
	);

	assign event_code      = res.code;
	assign slot_index      = res.slot;
	assign flow_packets    = res.pkts;
	assign key_addr_low    = res.key.a_lo;
	assign key_addr_high   = res.key.a_hi;
	assign key_port_first  = res.key.p_first;
	assign key_port_second = res.key.p_second;
	assign key_proto       = res.key.proto;
	assign last_of_run     = res.last;

endmodule
